### design/ordered_timeout_list_top_assert.svh
// ============================================================================
// Assertion macros for the ordered timeout list
// Shared forms for the concurrent assertions of the port checker.
// ============================================================================
`ifndef ORDERED_TIMEOUT_LIST_TOP_ASSERT_SVH
`define ORDERED_TIMEOUT_LIST_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OTL_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/otl_pkg.sv
// ============================================================================
// otl_pkg
// Constants and codes shared by the ordered timeout list files.
// ============================================================================
`timescale 1ns / 1ps

package otl_pkg;

    // Default sizes.
    localparam int DEF_ENTRY_COUNT = 64;
    localparam int DEF_TIME_WIDTH  = 32;

    // Request and result field widths.
    localparam int MODE_WIDTH     = 3;
    localparam int KIND_WIDTH     = 2;
    localparam int INTERVAL_WIDTH = 32;

    // Request modes.
    localparam logic [MODE_WIDTH-1:0] MODE_START   = 3'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_STOP    = 3'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_TICK    = 3'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_RESTART = 3'd3;
    localparam logic [MODE_WIDTH-1:0] MODE_NEXT    = 3'd4;

    // Result kinds.
    localparam logic [KIND_WIDTH-1:0] KIND_EXPIRED = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_ITER    = 2'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_DONE    = 2'd2;

    // Register port.
    localparam int APB_ADDR_WIDTH  = 3;
    localparam int APB_DATA_WIDTH  = 32;
    localparam int REG_INDEX_WIDTH = APB_ADDR_WIDTH - 2;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_TIMEOUT_INTERVAL = 1'd0;

endpackage

### design/ordered_timeout_list_top.sv
// ============================================================================
// ordered_timeout_list_top
// One timer group kept as a doubly linked list of entry ids in start order.
// ============================================================================
// After reset the block clears the membership bits of every link memory word
// and takes no request during that pass; register writes are taken at any
// time. Requests are then handled one at a time by a sequencer that reads,
// modifies and writes back a link memory (membership, next and previous id
// per entry) and a time stamp memory, both with registered read data. The
// work for a start or stop depends on how many neighbor entries need their
// links patched (one read and one write each, with the read of one neighbor
// overlapping the write of the other). A start or stop with the reserved
// id, and a request with an unknown mode, goes straight to its result. A
// tick removes expired entries from the head and stops at the end of the
// list or at an entry that has not expired. Every result waits in a single
// output register, so a stall on the result side holds the sequencer until
// that register is free. Entry id 0 means none; ids from 1 to ENTRY_COUNT-1
// are usable.
// ============================================================================
`timescale 1ns / 1ps

module ordered_timeout_list_top #(
    parameter int  ENTRY_COUNT = otl_pkg::DEF_ENTRY_COUNT,
    parameter int  TIME_WIDTH  = otl_pkg::DEF_TIME_WIDTH,
    localparam int ID_WIDTH    = $clog2(ENTRY_COUNT)
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // Register port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [otl_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [otl_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [otl_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                pready,

    // Request channel.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [otl_pkg::MODE_WIDTH-1:0]      mode,
    input  logic [ID_WIDTH-1:0]                 entry_id,
    input  logic [TIME_WIDTH-1:0]               now,

    // Result channel.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [otl_pkg::KIND_WIDTH-1:0]      result_kind,
    output logic [ID_WIDTH-1:0]                 result_id,
    output logic                                last
);

    import otl_pkg::*;

    // The age compare is done at the wider of the time and interval widths.
    localparam int CMP_WIDTH = (TIME_WIDTH > INTERVAL_WIDTH) ? TIME_WIDTH : INTERVAL_WIDTH;
    localparam logic [ID_WIDTH:0] ENTRY_COUNT_EXT = (ID_WIDTH + 1)'(ENTRY_COUNT);
    localparam logic [ID_WIDTH-1:0] LAST_ENTRY = ID_WIDTH'(ENTRY_COUNT - 1);

    // Sequencer states.
    localparam logic [3:0] ST_CLEAR = 4'd0;   // clearing pass after reset
    localparam logic [3:0] ST_IDLE  = 4'd1;   // ready for a request
    localparam logic [3:0] ST_LOOK  = 4'd2;   // link word of the request id is back
    localparam logic [3:0] ST_FIXP  = 4'd3;   // patch next link of the predecessor
    localparam logic [3:0] ST_FIXN  = 4'd4;   // patch prev link of the successor
    localparam logic [3:0] ST_WRID  = 4'd5;   // write the entry itself
    localparam logic [3:0] ST_FIXT  = 4'd6;   // patch next link of the old tail
    localparam logic [3:0] ST_TLOOK = 4'd7;   // tick: head entry is back
    localparam logic [3:0] ST_ITER  = 4'd8;   // iterator entry is back
    localparam logic [3:0] ST_DONE  = 4'd9;   // give the final result

    // One word of the link memory.
    typedef struct packed {
        logic                in_list;
        logic [ID_WIDTH-1:0] next_id;
        logic [ID_WIDTH-1:0] prev_id;
    } link_t;

    localparam int LINK_WIDTH = $bits(link_t);

    // Control state.
    logic [3:0]                state_reg, state_next;
    logic [ID_WIDTH-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [ID_WIDTH-1:0]       head_reg, head_next;
    logic [ID_WIDTH-1:0]       tail_reg, tail_next;
    logic [ID_WIDTH-1:0]       iter_reg, iter_next;
    logic [INTERVAL_WIDTH-1:0] interval_reg, interval_next;
    logic                      out_valid_reg, out_valid_next;

    // Working registers of the request in flight.
    logic [MODE_WIDTH-1:0]     mode_reg, mode_next;
    logic [ID_WIDTH-1:0]       id_reg, id_next;
    logic [TIME_WIDTH-1:0]     now_reg, now_next;
    logic [ID_WIDTH-1:0]       p_reg, p_next;
    logic [ID_WIDTH-1:0]       n_reg, n_next;
    logic                      was_in_reg, was_in_next;
    logic [ID_WIDTH-1:0]       fix_reg, fix_next;
    logic [KIND_WIDTH-1:0]     fin_kind_reg, fin_kind_next;
    logic [ID_WIDTH-1:0]       fin_id_reg, fin_id_next;

    // Output register payload.
    logic [KIND_WIDTH-1:0]     kind_reg, kind_next;
    logic [ID_WIDTH-1:0]       rid_reg, rid_next;
    logic                      last_reg, last_next;

    // Memory ports.
    logic                      l_we, l_re;
    logic [ID_WIDTH-1:0]       l_waddr, l_raddr;
    link_t                     l_wdata, l_rdata;
    logic                      s_we, s_re;
    logic [ID_WIDTH-1:0]       s_waddr, s_raddr;
    logic [TIME_WIDTH-1:0]     s_wdata, s_rdata;

    // Handshake and helpers.
    logic                      accept;
    logic                      out_free;
    logic                      id_ok;
    logic                      cfg_write;
    logic                      emit;
    logic [KIND_WIDTH-1:0]     emit_kind;
    logic [ID_WIDTH-1:0]       emit_id;
    logic                      emit_last;
    logic [TIME_WIDTH-1:0]     age;
    logic                      expired;

    // ------------------------------------------------------------------------
    // Memories: link words and start stamps, one entry per id.
    // ------------------------------------------------------------------------
    otl_ram #(
        .WIDTH (LINK_WIDTH),
        .DEPTH (ENTRY_COUNT)
    ) u_link_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .re    (l_re),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    otl_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (ENTRY_COUNT)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // ------------------------------------------------------------------------
    // Register port. Only the timeout interval exists; other addresses read
    // as zero and ignore writes.
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[APB_ADDR_WIDTH-1:2] == REG_TIMEOUT_INTERVAL);
    assign prdata    = (paddr[APB_ADDR_WIDTH-1:2] == REG_TIMEOUT_INTERVAL)
                       ? APB_DATA_WIDTH'(interval_reg) : '0;

    // ------------------------------------------------------------------------
    // Handshake. A request is taken only in the idle state; the output
    // register may still hold an earlier result at that time.
    // ------------------------------------------------------------------------
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Id 0 is reserved, and ids beyond the table are treated the same way.
    assign id_ok = (entry_id != '0) && ({1'b0, entry_id} < ENTRY_COUNT_EXT);

    // Wrapped age of the entry whose stamp is on the read port.
    assign age     = now_reg - s_rdata;
    assign expired = CMP_WIDTH'(age) >= CMP_WIDTH'(interval_reg);

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign result_id   = rid_reg;
    assign last        = last_reg;

    // ------------------------------------------------------------------------
    // Sequencer.
    // Every memory read is issued one state ahead of its use. A read never
    // targets the entry written in the same cycle, so no forwarding is
    // needed: a value written in one state is seen by any later read.
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        iter_next     = iter_reg;
        interval_next = interval_reg;
        mode_next     = mode_reg;
        id_next       = id_reg;
        now_next      = now_reg;
        p_next        = p_reg;
        n_next        = n_reg;
        was_in_next   = was_in_reg;
        fix_next      = fix_reg;
        fin_kind_next = fin_kind_reg;
        fin_id_next   = fin_id_reg;

        l_we    = 1'b0;
        l_waddr = id_reg;
        l_wdata = '0;
        l_re    = 1'b0;
        l_raddr = id_reg;
        s_we    = 1'b0;
        s_waddr = id_reg;
        s_wdata = now_reg;
        s_re    = 1'b0;
        s_raddr = id_reg;

        emit      = 1'b0;
        emit_kind = fin_kind_reg;
        emit_id   = fin_id_reg;
        emit_last = 1'b1;

        if (cfg_write)
        begin
            interval_next = pwdata[INTERVAL_WIDTH-1:0];
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // Zero one link word a cycle so that no entry is a member.
                l_we         = 1'b1;
                l_waddr      = clr_cnt_reg;
                l_wdata      = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ENTRY)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next     = mode;
                    id_next       = entry_id;
                    now_next      = now;
                    fin_kind_next = KIND_DONE;
                    fin_id_next   = '0;
                    state_next    = ST_DONE;
                    case (mode)
                        MODE_START, MODE_STOP:
                        begin
                            if (id_ok)
                            begin
                                l_re       = 1'b1;
                                l_raddr    = entry_id;
                                state_next = ST_LOOK;
                            end
                        end
                        MODE_TICK:
                        begin
                            // The walk always starts at the head.
                            if (head_reg != '0)
                            begin
                                l_re       = 1'b1;
                                l_raddr    = head_reg;
                                s_re       = 1'b1;
                                s_raddr    = head_reg;
                                id_next    = head_reg;
                                state_next = ST_TLOOK;
                            end
                        end
                        MODE_RESTART:
                        begin
                            iter_next     = head_reg;
                            fin_kind_next = KIND_ITER;
                            fin_id_next   = head_reg;
                        end
                        MODE_NEXT:
                        begin
                            fin_kind_next = KIND_ITER;
                            if (iter_reg != '0)
                            begin
                                l_re       = 1'b1;
                                l_raddr    = iter_reg;
                                state_next = ST_ITER;
                            end
                        end
                        default:
                        begin
                            // Unknown modes are only acknowledged.
                        end
                    endcase
                end
            end

            ST_LOOK:
            begin
                // A member is unlinked first; the list registers move now and
                // the neighbors are patched in the following states.
                p_next      = l_rdata.prev_id;
                n_next      = l_rdata.next_id;
                was_in_next = l_rdata.in_list;
                state_next  = ST_WRID;
                if (l_rdata.in_list)
                begin
                    if (head_reg == id_reg)
                    begin
                        head_next = l_rdata.next_id;
                    end
                    if (tail_reg == id_reg)
                    begin
                        tail_next = l_rdata.prev_id;
                    end
                    if (iter_reg == id_reg)
                    begin
                        iter_next = l_rdata.next_id;
                    end
                    if (l_rdata.prev_id != '0)
                    begin
                        l_re       = 1'b1;
                        l_raddr    = l_rdata.prev_id;
                        state_next = ST_FIXP;
                    end
                    else if (l_rdata.next_id != '0)
                    begin
                        l_re       = 1'b1;
                        l_raddr    = l_rdata.next_id;
                        state_next = ST_FIXN;
                    end
                end
            end

            ST_FIXP:
            begin
                l_we    = 1'b1;
                l_waddr = p_reg;
                l_wdata = '{in_list: l_rdata.in_list, next_id: n_reg, prev_id: l_rdata.prev_id};
                if (n_reg != '0)
                begin
                    l_re       = 1'b1;
                    l_raddr    = n_reg;
                    state_next = ST_FIXN;
                end
                else
                begin
                    state_next = ST_WRID;
                end
            end

            ST_FIXN:
            begin
                l_we       = 1'b1;
                l_waddr    = n_reg;
                l_wdata    = '{in_list: l_rdata.in_list, next_id: l_rdata.next_id, prev_id: p_reg};
                state_next = ST_WRID;
            end

            ST_WRID:
            begin
                state_next = ST_DONE;
                if (mode_reg == MODE_START)
                begin
                    // Append behind the tail left by the unlink step.
                    l_we    = 1'b1;
                    l_waddr = id_reg;
                    l_wdata = '{in_list: 1'b1, next_id: '0, prev_id: tail_reg};
                    s_we    = 1'b1;
                    s_waddr = id_reg;
                    s_wdata = now_reg;
                    if (tail_reg != '0)
                    begin
                        l_re       = 1'b1;
                        l_raddr    = tail_reg;
                        fix_next   = tail_reg;
                        state_next = ST_FIXT;
                    end
                    if (head_reg == '0)
                    begin
                        head_next = id_reg;
                    end
                    tail_next = id_reg;
                end
                else if (was_in_reg)
                begin
                    l_we    = 1'b1;
                    l_waddr = id_reg;
                    l_wdata = '{in_list: 1'b0, next_id: n_reg, prev_id: p_reg};
                end
            end

            ST_FIXT:
            begin
                l_we       = 1'b1;
                l_waddr    = fix_reg;
                l_wdata    = '{in_list: l_rdata.in_list, next_id: id_reg,
                               prev_id: l_rdata.prev_id};
                state_next = ST_DONE;
            end

            ST_TLOOK:
            begin
                // The entry under test is always the head, so its true
                // predecessor is none. Its stored prev link may still name an
                // entry removed earlier in this walk; it is rewritten as zero
                // when the walk stops here.
                if (expired)
                begin
                    if (out_free)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_EXPIRED;
                        emit_id   = id_reg;
                        emit_last = 1'b0;
                        l_we      = 1'b1;
                        l_waddr   = id_reg;
                        l_wdata   = '{in_list: 1'b0, next_id: l_rdata.next_id, prev_id: '0};
                        head_next = l_rdata.next_id;
                        if (tail_reg == id_reg)
                        begin
                            tail_next = '0;
                        end
                        if (iter_reg == id_reg)
                        begin
                            iter_next = l_rdata.next_id;
                        end
                        if (l_rdata.next_id != '0)
                        begin
                            l_re    = 1'b1;
                            l_raddr = l_rdata.next_id;
                            s_re    = 1'b1;
                            s_raddr = l_rdata.next_id;
                            id_next = l_rdata.next_id;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                end
                else
                begin
                    l_we       = 1'b1;
                    l_waddr    = id_reg;
                    l_wdata    = '{in_list: l_rdata.in_list, next_id: l_rdata.next_id,
                                   prev_id: '0};
                    state_next = ST_DONE;
                end
            end

            ST_ITER:
            begin
                iter_next   = l_rdata.next_id;
                fin_id_next = l_rdata.next_id;
                state_next  = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Output register: loaded on emit, emptied when the result is taken.
    // ------------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        rid_next       = rid_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            kind_next      = emit_kind;
            rid_next       = emit_id;
            last_next      = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            iter_reg      <= '0;
            interval_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            iter_reg      <= iter_next;
            interval_reg  <= interval_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        id_reg       <= id_next;
        now_reg      <= now_next;
        p_reg        <= p_next;
        n_reg        <= n_next;
        was_in_reg   <= was_in_next;
        fix_reg      <= fix_next;
        fin_kind_reg <= fin_kind_next;
        fin_id_reg   <= fin_id_next;
        kind_reg     <= kind_next;
        rid_reg      <= rid_next;
        last_reg     <= last_next;
    end

endmodule

### design/otl_ram.sv
// ============================================================================
// otl_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ============================================================================
`timescale 1ns / 1ps

module otl_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/otl_checker.sv
// ============================================================================
// otl_checker
// Port-level checks of the ordered timeout list, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`include "ordered_timeout_list_top_assert.svh"

module otl_checker #(
    parameter int ID_WIDTH = 6
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [otl_pkg::KIND_WIDTH-1:0] result_kind,
    input logic [ID_WIDTH-1:0]            result_id,
    input logic                           last
);

    import otl_pkg::*;

    // A stalled result stays put.
    `OTL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(result_kind) && $stable(result_id) && $stable(last), "result changed while stalled")

    // Done and acknowledge results never carry an id.
    `OTL_ASSERT_HOLDS(a_done_no_id, clk, rst_n, out_valid && (result_kind == KIND_DONE), result_id == '0, "done result carries an id")

    // Only expired-entry results are followed by more results of the request.
    `OTL_ASSERT_HOLDS(a_kind_last, clk, rst_n, out_valid, ((result_kind == KIND_EXPIRED) && !last) || ((result_kind == KIND_ITER) && last) || ((result_kind == KIND_DONE) && last), "bad kind and last pairing")

    // Requests are handled one at a time.
    `OTL_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall, "request taken while busy")

endmodule

bind ordered_timeout_list_top otl_checker #(
    .ID_WIDTH (ID_WIDTH)
) u_otl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .result_id   (result_id),
    .last        (last)
);

### test/ordered_timeout_list_top_test.sv
// ============================================================================
// ordered_timeout_list_top_test
// Checks the ordered timeout list against a behavioral mirror of its list.
// Directed requests cover the corner cases first, then four random phases
// run with different expiry intervals and different sender and receiver
// idling. Every accepted result is compared with the mirror's prediction.
// ============================================================================
`timescale 1ns / 1ps

import otl_pkg::*;

typedef bit [$clog2(DEF_ENTRY_COUNT)-1:0] entry_t;
typedef bit [DEF_TIME_WIDTH-1:0]          stamp_t;

typedef struct packed {
    bit [KIND_WIDTH-1:0] kind;
    entry_t              id;
    bit                  last;
} timer_result_t;

// Behavioral copy of the timer list; predicts the results of each request.
class timeout_list_mirror;
    entry_t          fwd_link [DEF_ENTRY_COUNT];
    entry_t          back_link[DEF_ENTRY_COUNT];
    stamp_t          started  [DEF_ENTRY_COUNT];
    bit              member   [DEF_ENTRY_COUNT];
    entry_t          head;
    entry_t          tail;
    entry_t          cursor;
    stamp_t          expiry_interval;
    timer_result_t   due_results[$];
    int              fault_count;

    function new();
        foreach (member[i]) begin
            member[i] = 1'b0;
        end
        head            = '0;
        tail            = '0;
        cursor          = '0;
        expiry_interval = '0;
        fault_count     = 0;
    endfunction

    function void owe(bit [KIND_WIDTH-1:0] kind, entry_t id, bit last_flag);
        timer_result_t r;
        r.kind = kind;
        r.id   = id;
        r.last = last_flag;
        due_results.push_back(r);
    endfunction

    function void unlink(entry_t id);
        entry_t p;
        entry_t n;
        p = back_link[id];
        n = fwd_link[id];
        if (p != 0) fwd_link[p] = n;
        if (n != 0) back_link[n] = p;
        if (head == id) head = n;
        if (tail == id) tail = p;
        if (cursor == id) cursor = n;
        member[id] = 1'b0;
    endfunction

    function void append(entry_t id, stamp_t t);
        started[id]  = t;
        fwd_link[id] = '0;
        if (head == 0) begin
            head          = id;
            tail          = id;
            back_link[id] = '0;
        end
        else begin
            back_link[id]  = tail;
            fwd_link[tail] = id;
            tail           = id;
        end
        member[id] = 1'b1;
    endfunction

    function void take_request(bit [MODE_WIDTH-1:0] op, entry_t id, stamp_t t);
        entry_t walk;
        stamp_t age;
        int     count;
        bit     scanning;
        case (op)
            MODE_START, MODE_STOP:
            begin
                if (id != 0) begin
                    if (member[id]) unlink(id);
                    if (op == MODE_START) append(id, t);
                end
                owe(KIND_DONE, '0, 1'b1);
            end
            MODE_TICK:
            begin
                walk     = head;
                count    = 0;
                scanning = 1'b1;
                while (scanning && walk != 0 && count < DEF_ENTRY_COUNT - 1 && member[walk]) begin
                    age = t - started[walk];
                    if (age < expiry_interval) begin
                        scanning = 1'b0;
                    end
                    else begin
                        unlink(walk);
                        owe(KIND_EXPIRED, walk, 1'b0);
                        count++;
                        walk = fwd_link[walk];
                    end
                end
                owe(KIND_DONE, '0, 1'b1);
            end
            MODE_RESTART:
            begin
                cursor = head;
                owe(KIND_ITER, cursor, 1'b1);
            end
            MODE_NEXT:
            begin
                if (cursor != 0) cursor = fwd_link[cursor];
                owe(KIND_ITER, cursor, 1'b1);
            end
            default:
            begin
                owe(KIND_DONE, '0, 1'b1);
            end
        endcase
    endfunction

    function void match_result(logic [KIND_WIDTH-1:0] kind, logic [$bits(entry_t)-1:0] id,
                               logic last_flag);
        timer_result_t want;
        if (due_results.size() == 0) begin
            $error("unexpected result: result_kind %0d result_id %0d last %0d",
                   kind, id, last_flag);
            fault_count++;
            return;
        end
        want = due_results.pop_front();
        if (kind !== want.kind) begin
            $error("result_kind: expected %0d, actual %0d", want.kind, kind);
            fault_count++;
        end
        if (id !== want.id) begin
            $error("result_id: expected %0d, actual %0d", want.id, id);
            fault_count++;
        end
        if (last_flag !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last_flag);
            fault_count++;
        end
    endfunction
endclass

module ordered_timeout_list_top_test;

    // Modes 5 to 7 are unused by the block; it only acknowledges them.
    localparam logic [MODE_WIDTH-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_WIDTH-1:0] MODE_SPARE_LAST  = 3'd7;

    localparam logic [APB_ADDR_WIDTH-1:0] INTERVAL_ADDR = {REG_TIMEOUT_INTERVAL, 2'b00};

    localparam int     RANDOM_PER_PHASE = 62;
    localparam int     PHASE_COUNT      = 4;
    localparam int     SETTLE_CYCLES    = 40;
    localparam int     CYCLE_LIMIT      = 400000;
    localparam stamp_t INTERVAL_MAX     = '1;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [APB_ADDR_WIDTH-1:0]   paddr;
    logic [APB_DATA_WIDTH-1:0]   pwdata;
    logic [APB_DATA_WIDTH-1:0]   prdata;
    logic                        pready;
    logic                        in_valid;
    logic                        in_stall;
    logic [MODE_WIDTH-1:0]       mode;
    logic [$bits(entry_t)-1:0]   entry_id;
    logic [DEF_TIME_WIDTH-1:0]   now;
    logic                        out_valid;
    logic                        out_stall;
    logic [KIND_WIDTH-1:0]       result_kind;
    logic [$bits(entry_t)-1:0]   result_id;
    logic                        last;

    timeout_list_mirror mirror;

    // Percentages of cycles in which the sender holds back a request and in
    // which the receiver stalls a result; both are set anew for each phase.
    int     send_idle_pct;
    int     stall_pct;
    int     cycle_count;
    stamp_t run_clock;

    ordered_timeout_list_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .entry_id    (entry_id),
        .now         (now),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .result_id   (result_id),
        .last        (last)
    );

    always #5 clk = ~clk;

    // The receiver stalls at random at the rate set for the current phase.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Every result taken by the receiver is checked against the oldest
    // prediction; values are those from just before the edge.
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
            mirror.match_result(result_kind, result_id, last);
        end
    end

    // Watchdog: a hung block or a lost result ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ordered_timeout_list_top_test failed");
            $finish;
        end
    end

    // Presents one request and holds it until the block takes it. Valid is
    // left high afterwards so that a request that follows at once is not
    // broken by a second assignment in the same time step; the next call or
    // the drain lowers it.
    task automatic issue(input logic [MODE_WIDTH-1:0] op, input entry_t id, input stamp_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        entry_id <= id;
        now      <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        mirror.take_request(op, id, t);
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (mirror.due_results.size() != 0) @(posedge clk);
    endtask

    // Writes the expiry interval over the register port and reads it back.
    task automatic set_interval(input stamp_t value);
        logic [APB_DATA_WIDTH-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= INTERVAL_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        // Write done at this edge; go straight into the setup of a read.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        readback = prdata;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        mirror.expiry_interval = value;
        if (readback !== value) begin
            $error("timeout_interval: expected %0h, actual %0h", value, readback);
            mirror.fault_count++;
        end
    endtask

    // Random traffic. Most requests are well-formed timer use on a small
    // pool of ids with time advancing slowly, so that restarts, stops in the
    // middle of the list and partial expiry all happen often. The rest is
    // noise: ids outside the pool, the reserved id, wild time stamps and
    // unused modes.
    task automatic random_requests(input int count, input int pool);
        int     pick;
        entry_t id;
        stamp_t t;
        repeat (count) begin
            pick      = $urandom_range(99);
            run_clock = run_clock + $urandom_range(0, 12);
            t         = run_clock;
            if ($urandom_range(9) == 0) begin
                id = entry_t'($urandom_range(0, DEF_ENTRY_COUNT - 1));
            end
            else begin
                id = entry_t'($urandom_range(1, pool));
            end
            if (pick < 40) begin
                issue(MODE_START, id, t);
            end
            else if (pick < 60) begin
                issue(MODE_STOP, id, t);
            end
            else if (pick < 74) begin
                issue(MODE_TICK, id, t);
            end
            else if (pick < 82) begin
                issue(MODE_RESTART, id, t);
            end
            else if (pick < 93) begin
                issue(MODE_NEXT, id, t);
            end
            else if (pick < 97) begin
                issue(($urandom_range(1)) ? MODE_START : MODE_TICK, id, $urandom);
            end
            else begin
                issue(MODE_WIDTH'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)), id,
                      $urandom);
            end
        end
    endtask

    initial begin
        int     phase;
        int     send_plan [PHASE_COUNT];
        int     stall_plan[PHASE_COUNT];
        int     pool_plan [PHASE_COUNT];
        stamp_t interval_plan[PHASE_COUNT];

        mirror        = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        mode          = MODE_START;
        entry_id      = '0;
        now           = '0;
        out_stall     = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        cycle_count   = 0;

        // Phases: no idling, a slow sender, a slow receiver, then both.
        send_plan  = '{0, 71, 0, 20};
        stall_plan = '{0, 0, 71, 20};
        pool_plan  = '{12, 20, 63, 40};
        interval_plan = '{stamp_t'(0), stamp_t'(40), stamp_t'($urandom_range(1, 200)),
                          INTERVAL_MAX};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset interval of zero, where every entry has
        // expired by the time of any tick. The block is still clearing its
        // memory after reset; the first request simply waits on the stall.
        issue(MODE_TICK, '0, 32'd0);               // tick on an empty list
        issue(MODE_NEXT, '0, 32'd0);               // next with no iterator
        issue(MODE_START, '0, 32'd0);              // the reserved id is ignored
        issue(MODE_START, 6'd63, 32'd0);           // highest id
        issue(MODE_START, 6'd1, 32'hFFFF_FFFF);
        issue(MODE_START, 6'd5, 32'd0);
        issue(MODE_RESTART, '0, 32'd0);            // iterator on the head
        issue(MODE_NEXT, '0, 32'd0);               // iterator on 1
        issue(MODE_STOP, 6'd1, 32'd0);             // stop under the iterator
        issue(MODE_NEXT, '0, 32'd0);               // walks off the end
        issue(MODE_START, 6'd63, 32'd100);         // restart moves 63 to the tail
        issue(MODE_STOP, 6'd7, 32'd0);             // stopping an absent id
        issue(MODE_SPARE_FIRST, 6'd5, 32'd0);      // unused modes
        issue(MODE_SPARE_LAST, 6'd63, 32'hFFFF_FFFF);
        issue(MODE_TICK, '0, 32'd0);               // everything expires
        drain();

        // Directed part at the largest interval: only an age of all ones
        // expires, and the tick stops at the first live entry.
        set_interval(INTERVAL_MAX);
        issue(MODE_START, 6'd2, 32'd1);
        issue(MODE_START, 6'd3, 32'd0);
        issue(MODE_START, 6'd4, 32'hFFFF_FFFF);
        issue(MODE_TICK, '0, 32'd0);
        issue(MODE_RESTART, '0, 32'd0);
        issue(MODE_STOP, 6'd3, 32'd0);             // stop at the head
        issue(MODE_NEXT, '0, 32'd0);
        issue(MODE_STOP, 6'd4, 32'd0);             // stop at the tail
        issue(MODE_STOP, '0, 32'd0);
        issue(MODE_TICK, '0, 32'hFFFF_FFFE);

        // Start near the top of the time range so that it wraps early on.
        run_clock = 32'hFFFF_FF80;
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            drain();
            send_idle_pct = send_plan[phase];
            stall_pct     = stall_plan[phase];
            set_interval(interval_plan[phase]);
            random_requests(RANDOM_PER_PHASE, pool_plan[phase]);
        end
        drain();

        // Give a stray extra result the time to show up before judging.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mirror.fault_count == 0) begin
            $display("ordered_timeout_list_top_test passed");
        end
        else begin
            $display("ordered_timeout_list_top_test failed");
        end
        $finish;
    end

endmodule

### ordered_timeout_list_top.f
+incdir+design
design/otl_pkg.sv
design/otl_ram.sv
design/ordered_timeout_list_top.sv
design/otl_checker.sv
test/ordered_timeout_list_top_test.sv
